// ===== rtl/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  localparam int ENTRY_W   = 6;
  localparam int SIZE_W    = 5;
  localparam int ALLOC_BIT = 5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_FIT      = 3'd1;
  localparam logic [2:0] ST_REFUSED     = 3'd2;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC   = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

// ===== rtl/bba_table_ram.sv =====
// Block table memory: one write port, one registered read port.
module bba_table_ram import bba_pkg::*; #(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [2**AW];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/buddy_block_allocator_top.sv =====
// Buddy block allocator: control sequencer around the block table memory.
//
//  channel | ports                                                  | handshake
//  input   | in_opcode, in_request_bytes, in_address                | start & !busy
//  result  | out_status, out_granted_address, out_granted_size_log2 | out_valid, one cycle
//
// Allocate: one table read per granule, a select step, one write per split and
// a write of the granted entry. Free: a rejected address is answered from idle;
// otherwise the entry is read and checked, then buddies are read and merged.
// The full table scan through the single read port sets the allocate time.
// After reset a clearing pass writes every entry, one per cycle, with busy high.
// Nothing stalls a result.
module buddy_block_allocator_top import bba_pkg::*; #(
  parameter int HEAP_LOG2    = 16,
  parameter int HEADER_BYTES = 24,
  parameter int GRANULE_LOG2 = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_address,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_granted_address,
  output logic [4:0]  out_granted_size_log2
);

  localparam int AW    = HEAP_LOG2 - GRANULE_LOG2;
  localparam int NGRAN = 1 << AW;
  localparam logic [SIZE_W-1:0] HEAP_SZ = SIZE_W'(HEAP_LOG2);
  localparam logic [SIZE_W-1:0] GRAN_SZ = SIZE_W'(GRANULE_LOG2);

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_SEL   = 10'b0000001000,
    S_SPLIT = 10'b0000010000,
    S_AWR   = 10'b0000100000,
    S_FISS  = 10'b0001000000,
    S_FCHK  = 10'b0010000000,
    S_BISS  = 10'b0100000000,
    S_BCHK  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW:0]       cnt_r, cnt_nxt;
  logic              rv_r, rv_nxt;
  logic [AW-1:0]     ridx_r, ridx_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     best_r, best_nxt;
  logic [SIZE_W-1:0] bsz_r, bsz_nxt;
  logic [1:0]        fcnt_r, fcnt_nxt;
  logic [16:0]       need_r, need_nxt;
  logic [SIZE_W-1:0] k_r, k_nxt;
  logic [SIZE_W-1:0] fin_r, fin_nxt;
  logic              refuse_r, refuse_nxt;
  logic [AW-1:0]     g_r, g_nxt;
  logic [AW-1:0]     bud_r, bud_nxt;
  logic [SIZE_W-1:0] sz_r, sz_nxt;
  logic [SIZE_W-1:0] freed_r, freed_nxt;
  logic              merge_r, merge_nxt;

  logic              ov_r, ov_nxt;
  logic [2:0]        ost_r, ost_nxt;
  logic [15:0]       oaddr_r, oaddr_nxt;
  logic [4:0]        osz_r, osz_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  bba_table_ram #(.AW(AW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // size bounds of the request: floor and ceiling log2 of header plus bytes
  logic [SIZE_W-1:0] fl, cl, fin;
  logic              pow2;
  always_comb begin
    fl = '0;
    for (int i = 0; i < 17; i++) begin
      if (need_r[i]) fl = SIZE_W'(i);
    end
    pow2 = ((need_r & (need_r - 17'd1)) == 17'd0);
    cl   = fl + SIZE_W'(!pow2);
    fin  = (bsz_r < fl + 5'd1) ? bsz_r : fl + 5'd1;
    if (fin < GRAN_SZ) fin = GRAN_SZ;
  end

  // free address checks
  logic [15:0] off;
  logic [31:0] gran32;
  logic        bad_addr;
  always_comb begin
    off      = in_address - 16'(HEADER_BYTES);
    gran32   = 32'(off >> GRANULE_LOG2);
    bad_addr = ({1'b0, in_address} < 17'(HEADER_BYTES)) ||
               ((off & 16'((1 << GRANULE_LOG2) - 1)) != 16'd0) ||
               (gran32 >= 32'(NGRAN));
  end

  logic [SIZE_W-1:0] es;
  logic              efree, efit;
  logic [31:0]       gaddr;
  assign es    = rdata[SIZE_W-1:0];
  assign efree = (es != '0) && !rdata[ALLOC_BIT];
  assign efit  = (es <= HEAP_SZ) && (es >= cl);
  assign gaddr = (32'(best_r) << GRANULE_LOG2) + 32'(HEADER_BYTES);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rv_nxt     = 1'b0;
    ridx_nxt   = ridx_r;
    found_nxt  = found_r;
    best_nxt   = best_r;
    bsz_nxt    = bsz_r;
    fcnt_nxt   = fcnt_r;
    need_nxt   = need_r;
    k_nxt      = k_r;
    fin_nxt    = fin_r;
    refuse_nxt = refuse_r;
    g_nxt      = g_r;
    bud_nxt    = bud_r;
    sz_nxt     = sz_r;
    freed_nxt  = freed_r;
    merge_nxt  = merge_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    oaddr_nxt  = oaddr_r;
    osz_nxt    = osz_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;

    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        waddr   = cnt_r[AW-1:0];
        wdata   = (cnt_r[AW-1:0] == '0) ? entry_t'(HEAP_SZ) : '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[AW-1:0] == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_opcode == OP_ALLOC) begin
            need_nxt  = 17'(HEADER_BYTES) + 17'(in_request_bytes);
            found_nxt = 1'b0;
            fcnt_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end else if (bad_addr) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_NOT_ALLOC;
            oaddr_nxt = '0;
            osz_nxt   = '0;
          end else begin
            g_nxt     = gran32[AW-1:0];
            state_nxt = S_FISS;
          end
        end
      end
      S_SCAN: begin
        if (!cnt_r[AW]) begin
          re       = 1'b1;
          raddr    = cnt_r[AW-1:0];
          rv_nxt   = 1'b1;
          ridx_nxt = cnt_r[AW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (rv_r) begin
          if (efree) begin
            if (fcnt_r != 2'd2) fcnt_nxt = fcnt_r + 2'd1;
            if (efit && (!found_r || es < bsz_r)) begin
              found_nxt = 1'b1;
              best_nxt  = ridx_r;
              bsz_nxt   = es;
            end
          end
          if (ridx_r == '1) state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (!found_r) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_NO_FIT;
          oaddr_nxt = '0;
          osz_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          fin_nxt    = fin;
          k_nxt      = fin;
          // a split always leaves a second free block
          refuse_nxt = (fcnt_r <= 2'd1) && (fin == bsz_r);
          state_nxt  = (fin < bsz_r) ? S_SPLIT : S_AWR;
        end
      end
      S_SPLIT: begin
        we    = 1'b1;
        waddr = best_r + (AW'(1) << (k_r - GRAN_SZ));
        wdata = entry_t'(k_r);
        k_nxt = k_r + 5'd1;
        if (k_r + 5'd1 == bsz_r) state_nxt = S_AWR;
      end
      S_AWR: begin
        we        = 1'b1;
        waddr     = best_r;
        wdata     = {!refuse_r, fin_r};
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        if (refuse_r) begin
          ost_nxt   = ST_REFUSED;
          oaddr_nxt = '0;
          osz_nxt   = '0;
        end else begin
          ost_nxt   = ST_OK;
          oaddr_nxt = gaddr[15:0];
          osz_nxt   = fin_r;
        end
      end
      S_FISS: begin
        re        = 1'b1;
        raddr     = g_r;
        merge_nxt = 1'b0;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (es == '0) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_NOT_ALLOC;
          oaddr_nxt = '0;
          osz_nxt   = '0;
          state_nxt = S_IDLE;
        end else if (!rdata[ALLOC_BIT]) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_ALREADY_FREE;
          oaddr_nxt = '0;
          osz_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          we        = 1'b1;
          waddr     = g_r;
          wdata     = entry_t'(es);
          sz_nxt    = es;
          freed_nxt = es;
          if (es < HEAP_SZ && es >= GRAN_SZ) begin
            state_nxt = S_BISS;
          end else begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_OK;
            oaddr_nxt = '0;
            osz_nxt   = es;
            state_nxt = S_IDLE;
          end
        end
      end
      S_BISS: begin
        // second half of a merge: write the grown block, then look again
        if (merge_r) begin
          we     = 1'b1;
          waddr  = g_r;
          wdata  = entry_t'(sz_r);
          merge_nxt = 1'b0;
          if (!(sz_r < HEAP_SZ && sz_r >= GRAN_SZ)) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_OK;
            oaddr_nxt = '0;
            osz_nxt   = freed_r;
            state_nxt = S_IDLE;
          end
        end else begin
          re        = 1'b1;
          raddr     = g_r ^ (AW'(1) << (sz_r - GRAN_SZ));
          bud_nxt   = g_r ^ (AW'(1) << (sz_r - GRAN_SZ));
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (rdata[ALLOC_BIT] || es != sz_r) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_OK;
          oaddr_nxt = '0;
          osz_nxt   = freed_r;
          state_nxt = S_IDLE;
        end else begin
          we = 1'b1;
          if (bud_r < g_r) begin
            waddr = g_r;
            g_nxt = bud_r;
          end else begin
            waddr = bud_r;
          end
          wdata     = '0;
          sz_nxt    = sz_r + 5'd1;
          merge_nxt = 1'b1;
          state_nxt = S_BISS;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
      merge_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
      merge_r <= merge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r   <= ridx_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    bsz_r    <= bsz_nxt;
    fcnt_r   <= fcnt_nxt;
    need_r   <= need_nxt;
    k_r      <= k_nxt;
    fin_r    <= fin_nxt;
    refuse_r <= refuse_nxt;
    g_r      <= g_nxt;
    bud_r    <= bud_nxt;
    sz_r     <= sz_nxt;
    freed_r  <= freed_nxt;
    ost_r    <= ost_nxt;
    oaddr_r  <= oaddr_nxt;
    osz_r    <= osz_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = ov_r;
  assign out_status            = ost_r;
  assign out_granted_address   = oaddr_r;
  assign out_granted_size_log2 = osz_r;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the buddy block allocator: directed and random items.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int HEAP_LOG2    = 16;
  localparam int HEADER_BYTES = 24;
  localparam int GRANULE_LOG2 = 5;
  localparam int NGRAN        = 1 << (HEAP_LOG2 - GRANULE_LOG2);
  localparam int N_RANDOM     = 265;
  localparam int LIMIT        = 4000000;

  typedef struct {
    logic        op;
    logic [15:0] req;
    logic [15:0] addr;
  } alloc_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] addr;
    logic [4:0]  size_log2;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [15:0] in_request_bytes;
  logic [15:0] in_address;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_granted_address;
  logic [4:0]  out_granted_size_log2;

  buddy_block_allocator_top #(
    .HEAP_LOG2(HEAP_LOG2), .HEADER_BYTES(HEADER_BYTES), .GRANULE_LOG2(GRANULE_LOG2)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_request_bytes(in_request_bytes), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status),
    .out_granted_address(out_granted_address),
    .out_granted_size_log2(out_granted_size_log2)
  );

  entry_t          blk_table [NGRAN];
  alloc_item_t     pending[$];
  alloc_result_t   expected[$];
  logic [15:0]     live_addrs[$];
  int              errors = 0;
  int              cycles = 0;
  int              idle_left = 0;
  bit              quiet = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NGRAN; i++) blk_table[i] = '0;
    blk_table[0] = entry_t'(HEAP_LOG2);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic alloc_result_t predict_alloc(logic [15:0] req);
    alloc_result_t r;
    int need, best, best_sz, free_count, sz, s;
    bit found;
    r = '{ST_OK, 16'd0, 5'd0};
    need = HEADER_BYTES + req;
    best = 0;
    best_sz = 0;
    found = 0;
    free_count = 0;
    for (int i = 0; i < NGRAN; i++) begin
      s = blk_table[i][SIZE_W-1:0];
      if (s == 0 || blk_table[i][ALLOC_BIT] || s > HEAP_LOG2) continue;
      if ((1 << s) >= need && (!found || s < best_sz)) begin
        found = 1;
        best = i;
        best_sz = s;
      end
    end
    if (!found) begin
      r.status = ST_NO_FIT;
      return r;
    end
    sz = best_sz;
    while (sz > GRANULE_LOG2 && (1 << (sz - 1)) > need) begin
      sz--;
      blk_table[(best + (1 << (sz - GRANULE_LOG2))) % NGRAN] = entry_t'(sz);
    end
    blk_table[best] = entry_t'(sz);
    for (int i = 0; i < NGRAN; i++)
      if (blk_table[i][SIZE_W-1:0] != 0 && !blk_table[i][ALLOC_BIT]) free_count++;
    if (free_count <= 1) begin
      r.status = ST_REFUSED;
      return r;
    end
    blk_table[best] = entry_t'(sz) | entry_t'(1 << ALLOC_BIT);
    r.addr = 16'((best << GRANULE_LOG2) + HEADER_BYTES);
    r.size_log2 = 5'(sz);
    live_addrs.push_back(r.addr);
    return r;
  endfunction

  function automatic alloc_result_t predict_free(logic [15:0] addr);
    alloc_result_t r;
    int off, g, sz, bud;
    r = '{ST_NOT_ALLOC, 16'd0, 5'd0};
    if (addr < HEADER_BYTES) return r;
    off = addr - HEADER_BYTES;
    if ((off % (1 << GRANULE_LOG2)) != 0 || (off >> GRANULE_LOG2) >= NGRAN) return r;
    g = off >> GRANULE_LOG2;
    if (blk_table[g][SIZE_W-1:0] == 0) return r;
    if (!blk_table[g][ALLOC_BIT]) begin
      r.status = ST_ALREADY_FREE;
      return r;
    end
    sz = blk_table[g][SIZE_W-1:0];
    r.status = ST_OK;
    r.size_log2 = 5'(sz);
    blk_table[g] = entry_t'(sz);
    while (sz < HEAP_LOG2 && sz >= GRANULE_LOG2) begin
      bud = g ^ (1 << (sz - GRANULE_LOG2));
      if (bud >= NGRAN) break;
      if (blk_table[bud][ALLOC_BIT] || blk_table[bud][SIZE_W-1:0] != sz) break;
      if (bud < g) begin
        blk_table[g] = '0;
        g = bud;
      end else begin
        blk_table[bud] = '0;
      end
      sz++;
      blk_table[g] = entry_t'(sz);
    end
    for (int i = 0; i < live_addrs.size(); i++)
      if (live_addrs[i] == addr) begin
        live_addrs.delete(i);
        break;
      end
    return r;
  endfunction

  // driver: holds an item until accepted, inserts random idle bursts between items
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_opcode <= OP_ALLOC;
      in_request_bytes <= '0;
      in_address <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        if (in_opcode == OP_ALLOC) expected.push_back(predict_alloc(in_request_bytes));
        else expected.push_back(predict_free(in_address));
        void'(pending.pop_front());
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 0;
      end else if (pending.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(0, 4);
        start <= 0;
      end else if (pending.size() > 0) begin
        start <= 1;
        in_opcode <= pending[0].op;
        in_request_bytes <= pending[0].req;
        in_address <= pending[0].addr;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid) begin
      if (expected.size() == 0) begin
        $error("result with no item outstanding: status %0d", out_status);
        errors++;
      end else begin
        e = expected.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (out_granted_address !== e.addr) begin
          $error("granted_address: expected %h, got %h", e.addr, out_granted_address);
          errors++;
        end
        if (out_granted_size_log2 !== e.size_log2) begin
          $error("granted_size_log2: expected %0d, got %0d", e.size_log2,
                 out_granted_size_log2);
          errors++;
        end
      end
    end
  end

  task automatic push_item(logic op, logic [15:0] req, logic [15:0] addr);
    while (pending.size() != 0) @(posedge clk);
    pending.push_back('{op, req, addr});
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || start || expected.size() != 0) @(posedge clk);
  endtask

  initial begin
    int k, pick;
    logic [15:0] a;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed
    push_item(OP_ALLOC, 16'hFFFF, 16'hFFFF);          // too large
    push_item(OP_ALLOC, 16'd65512, 16'h0000);         // whole heap, only free block
    push_item(OP_FREE, 16'hFFFF, 16'd24);             // heap block still free
    push_item(OP_FREE, 16'h0000, 16'd0);              // below header
    push_item(OP_FREE, 16'h0000, 16'd23);
    push_item(OP_FREE, 16'h0000, 16'd25);             // off granule boundary
    push_item(OP_FREE, 16'h0000, 16'hFFFF);
    push_item(OP_FREE, 16'h0000, 16'd120);            // no block starts there
    push_item(OP_ALLOC, 16'd0, 16'h0000);             // smallest block
    push_item(OP_ALLOC, 16'd8, 16'h0000);             // exactly one granule
    push_item(OP_ALLOC, 16'd9, 16'h0000);             // one byte over
    push_item(OP_ALLOC, 16'd32744, 16'h0000);         // half heap
    push_item(OP_ALLOC, 16'd32744, 16'h0000);         // no fit now
    wait_drained();
    // pressure: each live block freed in turn, the next sent once the last is accepted
    while (live_addrs.size() > 0) begin
      a = live_addrs[0];
      push_item(OP_FREE, 16'h1234, a);
      while (pending.size() != 0 || start) @(posedge clk);
    end
    push_item(OP_FREE, 16'h0000, 16'd24);             // double free after full merge
    wait_drained();

    // random
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 40) quiet = 1;
      while (pending.size() != 0) @(posedge clk);
      k = $urandom_range(0, 99);
      if (k < 55) begin
        if ($urandom_range(0, 9) == 0) push_item(OP_ALLOC, 16'($urandom), 16'($urandom));
        else push_item(OP_ALLOC, 16'($urandom_range(0, 400)), 16'($urandom));
      end else if (k < 90 && live_addrs.size() > 0) begin
        pick = $urandom_range(0, live_addrs.size() - 1);
        push_item(OP_FREE, 16'($urandom), live_addrs[pick]);
      end else if (k < 95) begin
        push_item(OP_FREE, 16'($urandom), 16'($urandom));
      end else begin
        push_item(OP_FREE, 16'($urandom), 16'(HEADER_BYTES + ($urandom_range(0, 63) << 5)));
      end
    end

    wait_drained();
    repeat (2200) @(posedge clk);
    if (expected.size() != 0) errors++;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bba_table_ram.sv
rtl/buddy_block_allocator_top.sv
test/tb_top.sv
